// File: design/wtmh_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wtmh_pkg: shared types and constants for the wrap-around timer heap
// Word layouts, status codes, engine states and the serial-number compare.
// ----------------------------------------------------------------------------
package wtmh_pkg;

   localparam int DefCapacity = 64;
   localparam int HandleW     = 6;
   localparam int NumHandles  = 1 << HandleW;
   localparam int KeyW        = 32;
   localparam int CountW      = 7;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_FULL    = 2'd1,
      ST_ABSENT  = 2'd2,
      ST_PRESENT = 2'd3
   } status_type;

   typedef enum logic {
      MODE_INSERT = 1'b0,
      MODE_REMOVE = 1'b1
   } mode_type;

   // heap engine sequencer
   typedef enum logic [3:0] {
      S_IDLE, S_RM_CHK, S_UP_RD, S_UP_WT, S_UP_CMP, S_SWAP_A,
      S_LAST_RD, S_LAST_WT, S_LAST_WR,
      S_DN_RDL, S_DN_RDR, S_DN_WT, S_DN_CMP, S_DONE
   } state_type;

   typedef struct packed {
      logic [0:0]         mode;
      logic [HandleW-1:0] handle;
      logic [KeyW-1:0]    key;
   } req_type;

   typedef struct packed {
      logic [HandleW-1:0] head_handle;
      logic [KeyW-1:0]    head_key;
      logic [CountW-1:0]  count;
      logic [1:0]         status;
   } rsp_type;

   // a is earlier than b when the 32-bit difference is negative
   function automatic logic earlier(input logic [KeyW-1:0] a, input logic [KeyW-1:0] b);
      logic [KeyW-1:0] d;
      d = a - b;
      return d[KeyW-1];
   endfunction

endpackage
`default_nettype wire

// File: design/wtmh_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wtmh_if: valid/ready channel
// Carries one word per handshake.
// ----------------------------------------------------------------------------
interface wtmh_if #(parameter int W = 1);
   logic         valid;
   logic         ready;
   logic [W-1:0] data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: design/wtmh_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wtmh_ram: generic single-port RAM
// One write or read per cycle, registered read data.
// ----------------------------------------------------------------------------
module wtmh_ram #(
   parameter int Width = 8,
   parameter int Depth = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(Depth)-1:0] addr,
   input  wire logic [Width-1:0]         wr_data,
   output logic      [Width-1:0]         rd_data
);
   logic [Width-1:0] mem [Depth];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data <= mem[addr];
   end
endmodule
`default_nettype wire

// File: design/wtmh_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wtmh_front: request queue
// Two-entry queue that holds accepted request words for the heap engine.
// ----------------------------------------------------------------------------
module wtmh_front (
   input  wire logic clock,
   input  wire logic reset,
   wtmh_if.sink      req,
   wtmh_if.source    cmd
);
   import wtmh_pkg::*;

   req_type    q_ff [2];
   req_type    q_in [2];
   logic [1:0] cnt_ff, cnt_in;
   logic       push, pop;

   assign req.ready = (cnt_ff != 2'd2);
   assign cmd.valid = (cnt_ff != 2'd0);
   assign cmd.data  = q_ff[0];
   assign push      = req.valid && req.ready;
   assign pop       = cmd.valid && cmd.ready;

   always_comb begin
      q_in   = q_ff;
      cnt_in = cnt_ff;
      if (pop) begin
         q_in[0] = q_ff[1];
         cnt_in  = cnt_in - 2'd1;
      end
      if (push) begin
         q_in[cnt_in[0]] = req.data;
         cnt_in          = cnt_in + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
      q_ff <= q_in;
   end
endmodule
`default_nettype wire

// File: design/wtmh_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wtmh_back: heap engine
// Sequencer that walks the heap one level at a time through the slot RAM.
// ----------------------------------------------------------------------------
module wtmh_back #(
   parameter int Capacity = wtmh_pkg::DefCapacity
) (
   input  wire logic clock,
   input  wire logic reset,
   wtmh_if.sink      cmd,
   wtmh_if.source    rsp
);
   import wtmh_pkg::*;

   localparam int SlotW = (Capacity > 1) ? $clog2(Capacity) : 1;
   localparam int CntW  = $clog2(Capacity + 1);
   localparam int EntW  = KeyW + HandleW;

   state_type          state_ff, state_in;
   logic [CntW-1:0]    count_ff, count_in;
   logic [SlotW-1:0]   pos_ff, pos_in, oth_ff, oth_in;
   logic [KeyW-1:0]    cur_key_ff, cur_key_in, head_key_ff, head_key_in;
   logic [HandleW-1:0] cur_hd_ff, cur_hd_in, head_hd_ff, head_hd_in;
   logic [EntW-1:0]    left_ff, left_in;
   logic               force_ff, force_in, has_r_ff, has_r_in;
   logic [1:0]         status_ff, status_in;
   logic               rsp_v_ff, rsp_v_in;
   logic [NumHandles-1:0] pres_ff, pres_in;
   req_type            c;

   logic               ram_we;
   logic [SlotW-1:0]   ram_addr;
   logic [EntW-1:0]    ram_wd, ram_rd;
   logic [KeyW-1:0]    rd_key;
   logic [HandleW-1:0] rd_hd;
   logic [SlotW-1:0]   parent;
   logic [SlotW:0]     lchild;

   logic               map_we;
   logic [HandleW-1:0] map_addr;
   logic [SlotW-1:0]   map_wd, map_rd;

   wtmh_ram #(.Width(EntW), .Depth(1 << SlotW)) u_slots (
      .clock(clock), .wr_en(ram_we), .addr(ram_addr), .wr_data(ram_wd), .rd_data(ram_rd)
   );

   // slot of each handle
   wtmh_ram #(.Width(SlotW), .Depth(NumHandles)) u_map (
      .clock(clock), .wr_en(map_we), .addr(map_addr), .wr_data(map_wd), .rd_data(map_rd)
   );

   assign c      = cmd.data;
   assign rd_key = ram_rd[KeyW-1:0];
   assign rd_hd  = ram_rd[EntW-1:KeyW];
   assign parent = (pos_ff - SlotW'(1)) >> 1;
   assign lchild = {pos_ff, 1'b1};

   assign cmd.ready = (state_ff == S_IDLE) && !rsp_v_ff;
   assign rsp.valid = rsp_v_ff;
   always_comb begin
      rsp_type r;
      r.head_handle = (count_ff != '0) ? head_hd_ff : '0;
      r.head_key    = (count_ff != '0) ? head_key_ff : '0;
      r.count       = CountW'(count_ff);
      r.status      = status_ff;
      rsp.data      = r;
   end

   always_comb begin
      state_in = state_ff;  count_in = count_ff;  pos_in = pos_ff;  oth_in = oth_ff;
      cur_key_in = cur_key_ff;  cur_hd_in = cur_hd_ff;
      head_key_in = head_key_ff;  head_hd_in = head_hd_ff;
      left_in = left_ff;  force_in = force_ff;  has_r_in = has_r_ff;
      status_in = status_ff;  rsp_v_in = rsp_v_ff;
      pres_in = pres_ff;
      ram_we = 1'b0;  ram_addr = pos_ff;  ram_wd = {cur_hd_ff, cur_key_ff};
      map_we = 1'b0;  map_addr = cur_hd_ff;  map_wd = pos_ff;
      if (rsp.valid && rsp.ready) rsp_v_in = 1'b0;
      case (state_ff)
         S_IDLE: begin
            map_addr = c.handle;
            if (cmd.valid && cmd.ready) begin
               status_in = ST_OK;
               if (c.mode == MODE_INSERT) begin
                  if (pres_ff[c.handle]) begin
                     status_in = ST_PRESENT;  state_in = S_DONE;
                  end else if (count_ff >= CntW'(Capacity)) begin
                     status_in = ST_FULL;  state_in = S_DONE;
                  end else begin
                     pos_in = SlotW'(count_ff);  count_in = count_ff + CntW'(1);
                     cur_key_in = c.key;  cur_hd_in = c.handle;
                     pres_in[c.handle] = 1'b1;
                     force_in = 1'b0;
                     state_in = S_UP_RD;
                  end
               end else begin
                  if (!pres_ff[c.handle]) begin
                     status_in = ST_ABSENT;  state_in = S_DONE;
                  end else begin
                     pres_in[c.handle] = 1'b0;
                     cur_hd_in = c.handle;
                     state_in = S_RM_CHK;
                  end
               end
            end
         end
         S_RM_CHK: begin
            // slot of the handle is back from the map
            if (CntW'(map_rd) == (count_ff - CntW'(1))) begin
               count_in = count_ff - CntW'(1);
               state_in = S_DONE;
            end else begin
               pos_in = map_rd;
               cur_key_in = head_key_ff - KeyW'(1);
               force_in = 1'b1;
               count_in = count_ff - CntW'(1);
               state_in = S_UP_RD;
            end
         end
         S_UP_RD: begin
            // write the moving entry in place, then read its parent
            ram_we = 1'b1;  ram_addr = pos_ff;
            map_we = 1'b1;  map_addr = cur_hd_ff;  map_wd = pos_ff;
            if (pos_ff == '0) begin
               head_key_in = cur_key_ff;  head_hd_in = cur_hd_ff;
               state_in = force_ff ? S_LAST_RD : S_DONE;
            end else begin
               state_in = S_UP_WT;
            end
         end
         S_UP_WT: begin
            ram_addr = parent;  state_in = S_UP_CMP;
         end
         S_UP_CMP: begin
            if (force_ff || earlier(cur_key_ff, rd_key)) begin
               // parent moves down into the current slot
               ram_we = 1'b1;  ram_addr = pos_ff;  ram_wd = ram_rd;
               map_we = 1'b1;  map_addr = rd_hd;  map_wd = pos_ff;
               pos_in = parent;
               state_in = S_UP_RD;
            end else begin
               state_in = S_DONE;
            end
         end
         S_LAST_RD: begin
            ram_addr = SlotW'(count_ff);  state_in = S_LAST_WT;
         end
         S_LAST_WT: begin
            ram_addr = SlotW'(count_ff);  state_in = S_LAST_WR;
         end
         S_LAST_WR: begin
            cur_key_in = rd_key;  cur_hd_in = rd_hd;  pos_in = '0;
            head_key_in = rd_key;  head_hd_in = rd_hd;
            ram_we = 1'b1;  ram_addr = '0;  ram_wd = ram_rd;
            map_we = 1'b1;  map_addr = rd_hd;  map_wd = '0;
            state_in = S_DN_RDL;
         end
         S_DN_RDL: begin
            if ((SlotW+1)'(lchild) >= (SlotW+1)'(count_ff)) begin
               state_in = S_DONE;
            end else begin
               ram_addr = lchild[SlotW-1:0];
               has_r_in = ((SlotW+1)'(lchild) + 1'b1) < (SlotW+1)'(count_ff);
               state_in = S_DN_RDR;
            end
         end
         S_DN_RDR: begin
            ram_addr = lchild[SlotW-1:0] + SlotW'(1);
            left_in = ram_rd;  state_in = S_DN_WT;
         end
         S_DN_WT: begin
            oth_in = lchild[SlotW-1:0];
            if (has_r_ff && earlier(rd_key, left_ff[KeyW-1:0])) begin
               left_in = ram_rd;
               oth_in = lchild[SlotW-1:0] + SlotW'(1);
            end
            state_in = S_DN_CMP;
         end
         S_DN_CMP: begin
            if (earlier(left_ff[KeyW-1:0], cur_key_ff)) begin
               ram_we = 1'b1;  ram_addr = pos_ff;  ram_wd = left_ff;
               map_we = 1'b1;  map_addr = left_ff[EntW-1:KeyW];  map_wd = pos_ff;
               if (pos_ff == '0) begin
                  head_key_in = left_ff[KeyW-1:0];  head_hd_in = left_ff[EntW-1:KeyW];
               end
               pos_in = oth_ff;
               state_in = S_SWAP_A;
            end else begin
               state_in = S_DONE;
            end
         end
         S_SWAP_A: begin
            ram_we = 1'b1;  ram_addr = pos_ff;
            map_we = 1'b1;  map_addr = cur_hd_ff;  map_wd = pos_ff;
            state_in = S_DN_RDL;
         end
         S_DONE: begin
            rsp_v_in = 1'b1;  state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;  count_ff <= '0;  pres_ff <= '0;  rsp_v_ff <= 1'b0;
      end else begin
         state_ff <= state_in;  count_ff <= count_in;  pres_ff <= pres_in;
         rsp_v_ff <= rsp_v_in;
      end
      pos_ff <= pos_in;  oth_ff <= oth_in;  cur_key_ff <= cur_key_in;  cur_hd_ff <= cur_hd_in;
      head_key_ff <= head_key_in;  head_hd_ff <= head_hd_in;  left_ff <= left_in;
      force_ff <= force_in;  has_r_ff <= has_r_in;  status_ff <= status_in;
   end
endmodule
`default_nettype wire

// File: design/wraparound_timer_min_heap.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wraparound_timer_min_heap: timer heap with wrap-around deadline order
// Binary min-heap of 32-bit deadlines with handle lookup, insert and remove.
// ----------------------------------------------------------------------------
// Each request word inserts a handle with a deadline or removes a handle;
// every word returns one response word with the earliest handle and key,
// the entry count and a status. Keys compare by their signed difference, so
// deadlines may wrap. The single slot RAM port sets the time: each level on
// the way up passes S_UP_RD, S_UP_WT and S_UP_CMP, each level on the way
// down S_DN_RDL, S_DN_RDR, S_DN_WT, S_DN_CMP and S_SWAP_A. An insert sifts
// up, and a remove that is not of the last slot sifts up then down. A
// two-word queue in front lets requests pile up while the engine works;
// words are taken one at a time by the engine.
// ----------------------------------------------------------------------------
module wraparound_timer_min_heap #(
   parameter int CAPACITY = wtmh_pkg::DefCapacity
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [0:0]  req_mode,
   input  wire logic [5:0]  req_handle,
   input  wire logic [31:0] req_key,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [5:0]       rsp_head_handle,
   output logic [31:0]      rsp_head_key,
   output logic [6:0]       rsp_count,
   output logic [1:0]       rsp_status
);
   import wtmh_pkg::*;

   localparam int ReqW = $bits(req_type);
   localparam int RspW = $bits(rsp_type);

   wtmh_if #(.W(ReqW)) req_ch ();
   wtmh_if #(.W(ReqW)) cmd_ch ();
   wtmh_if #(.W(RspW)) rsp_ch ();
   rsp_type r;

   assign req_ch.valid = req_valid;
   assign req_ch.data  = {req_mode, req_handle, req_key};
   assign req_ready    = req_ch.ready;

   wtmh_front u_front (.clock(clock), .reset(reset), .req(req_ch), .cmd(cmd_ch));

   wtmh_back #(.Capacity(CAPACITY)) u_back (
      .clock(clock), .reset(reset), .cmd(cmd_ch), .rsp(rsp_ch)
   );

   assign r               = rsp_ch.data;
   assign rsp_valid       = rsp_ch.valid;
   assign rsp_ch.ready    = rsp_ready;
   assign rsp_head_handle = r.head_handle;
   assign rsp_head_key    = r.head_key;
   assign rsp_count       = r.count;
   assign rsp_status      = r.status;
endmodule
`default_nettype wire

// File: bench/tb_wraparound_timer_min_heap.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_wraparound_timer_min_heap: self-checking bench for the timer heap
// Inserts and removes timers through the request channel, predicts every
// response word with a behavioural heap of its own and compares the words
// field by field as they leave, with random gaps on both channels.
// ----------------------------------------------------------------------------
module tb_wraparound_timer_min_heap;
   import wtmh_pkg::*;

   localparam int Cap = DefCapacity;

   logic clock = 1'b0;
   logic reset = 1'b1;

   always #5 clock = ~clock;

   // channels; the interface instances carry the packed words
   wtmh_if #(.W($bits(req_type))) req_ch ();
   wtmh_if #(.W($bits(rsp_type))) rsp_ch ();

   req_type req_word;
   rsp_type rsp_word;
   assign req_word = req_type'(req_ch.data);

   wraparound_timer_min_heap #(.CAPACITY(Cap)) u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_ch.valid),
      .req_ready       (req_ch.ready),
      .req_mode        (req_word.mode),
      .req_handle      (req_word.handle),
      .req_key         (req_word.key),
      .rsp_valid       (rsp_ch.valid),
      .rsp_ready       (rsp_ch.ready),
      .rsp_head_handle (rsp_word.head_handle),
      .rsp_head_key    (rsp_word.head_key),
      .rsp_count       (rsp_word.count),
      .rsp_status      (rsp_word.status)
   );
   assign rsp_ch.data = rsp_word;

   // ---------------------------------------------------------------------
   // Shadow heap: keys and handles per slot, slot per handle
   // ---------------------------------------------------------------------
   logic [31:0] hp_key [Cap];
   logic [5:0]  hp_hnd [Cap];
   int          hnd_pos [NumHandles];
   bit          hnd_live [NumHandles];
   int          hp_count;

   req_type pending_words[$];
   rsp_type expected_rsps[$];
   bit      stim_done = 1'b0;
   bit      calm = 1'b0;     // no idling in the last part of the run
   int      errors = 0;

   function automatic bit is_earlier(logic [31:0] a, logic [31:0] b);
      logic [31:0] d;
      d = a - b;
      return d[31];
   endfunction

   function automatic void swap_slots(int a, int b);
      logic [31:0] k;
      logic [5:0]  h;
      k = hp_key[a]; h = hp_hnd[a];
      hp_key[a] = hp_key[b]; hp_hnd[a] = hp_hnd[b];
      hp_key[b] = k; hp_hnd[b] = h;
      hnd_pos[hp_hnd[a]] = a;
      hnd_pos[hp_hnd[b]] = b;
   endfunction

   // applies one word to the shadow heap and returns the response it yields
   function automatic rsp_type heap_apply(req_type w);
      rsp_type r;
      int p, up, lc, pick;
      r.status = ST_OK;
      if (w.mode == MODE_INSERT) begin
         if (hnd_live[w.handle]) begin
            r.status = ST_PRESENT;
         end else if (hp_count >= Cap) begin
            r.status = ST_FULL;
         end else begin
            p = hp_count;
            hp_count++;
            hp_key[p] = w.key; hp_hnd[p] = w.handle;
            hnd_pos[w.handle] = p; hnd_live[w.handle] = 1'b1;
            while (p > 0) begin
               up = (p - 1) / 2;
               if (!is_earlier(hp_key[p], hp_key[up])) break;
               swap_slots(p, up);
               p = up;
            end
         end
      end else if (!hnd_live[w.handle]) begin
         r.status = ST_ABSENT;
      end else begin
         p = hnd_pos[w.handle];
         hnd_live[w.handle] = 1'b0;
         if (p == hp_count - 1) begin
            hp_count--;
         end else begin
            // force to the head whatever the key order says
            if (p != 0) begin
               hp_key[p] = hp_key[0] - 1;
               while (p > 0) begin
                  up = (p - 1) / 2;
                  swap_slots(p, up);
                  p = up;
               end
            end
            hp_count--;
            hp_key[0] = hp_key[hp_count];
            hp_hnd[0] = hp_hnd[hp_count];
            hnd_pos[hp_hnd[0]] = 0;
            p = 0;
            forever begin
               lc = 2 * p + 1;
               if (lc >= hp_count) break;
               pick = lc;
               if (lc + 1 < hp_count && is_earlier(hp_key[lc + 1], hp_key[lc]))
                  pick = lc + 1;
               if (!is_earlier(hp_key[pick], hp_key[p])) break;
               swap_slots(pick, p);
               p = pick;
            end
         end
      end
      r.head_handle = (hp_count > 0) ? hp_hnd[0] : '0;
      r.head_key    = (hp_count > 0) ? hp_key[0] : '0;
      r.count       = hp_count[6:0];
      return r;
   endfunction

   // ---------------------------------------------------------------------
   // Stimulus: a stimulus-side model tracks live handles so that most
   // removes hit and inserts mostly use free handles
   // ---------------------------------------------------------------------
   bit gen_live [NumHandles];
   int gen_count;

   task automatic push_word(logic m, logic [5:0] h, logic [31:0] k);
      req_type w;
      w.mode = m; w.handle = h; w.key = k;
      if (m == MODE_INSERT && !gen_live[h] && gen_count < Cap) begin
         gen_live[h] = 1'b1; gen_count++;
      end else if (m == MODE_REMOVE && gen_live[h]) begin
         gen_live[h] = 1'b0; gen_count--;
      end
      pending_words.push_back(w);
   endtask

   function automatic logic [5:0] pick_handle(bit want_live);
      logic [5:0] h;
      h = 6'($urandom_range(0, NumHandles - 1));
      for (int i = 0; i < NumHandles; i++) begin
         if (gen_live[h] == want_live) return h;
         h++;
      end
      return h;
   endfunction

   initial begin
      logic [31:0] base;
      int fill_target;
      for (int i = 0; i < NumHandles; i++) gen_live[i] = 1'b0;
      gen_count = 0;
      // directed: empty remove, extremes, wrap-around keys, duplicates
      push_word(MODE_REMOVE, 6'd0, 32'h0);
      push_word(MODE_INSERT, 6'd0, 32'hFFFF_FFFF);
      push_word(MODE_INSERT, 6'd63, 32'h0000_0000);       // wraps: later than -1
      push_word(MODE_INSERT, 6'd63, 32'h1234_5678);       // already present
      push_word(MODE_INSERT, 6'd5, 32'h8000_0000);        // 2^31 apart
      push_word(MODE_INSERT, 6'd6, 32'h7FFF_FFFF);
      push_word(MODE_INSERT, 6'd7, 32'h0000_0000);        // equal key
      push_word(MODE_INSERT, 6'd42, 32'hAAAA_5555);
      push_word(MODE_REMOVE, 6'd42, 32'hFFFF_FFFF);       // maybe last slot
      push_word(MODE_REMOVE, 6'd5, 32'h0);                // head slot
      push_word(MODE_REMOVE, 6'd0, 32'h0);                // head
      push_word(MODE_REMOVE, 6'd0, 32'h0);                // now absent
      push_word(MODE_REMOVE, 6'd63, 32'h0);
      push_word(MODE_REMOVE, 6'd6, 32'h0);
      push_word(MODE_REMOVE, 6'd7, 32'h0);                // back to empty
      // fill completely, then a repeat insert is refused as present
      base = $urandom;
      for (int i = 0; i < NumHandles; i++)
         push_word(MODE_INSERT, i[5:0], base + $urandom_range(0, 4000) - 2000);
      push_word(MODE_INSERT, 6'd9, 32'h0);
      // random: phases that grow and shrink the heap, keys mostly near a moving base
      fill_target = 32;
      for (int n = 0; n < 470; n++) begin
         logic [31:0] k;
         int r;
         if (n % 90 == 0) fill_target = $urandom_range(0, Cap);
         r = $urandom_range(0, 99);
         case ($urandom_range(0, 3))
            0: k = $urandom;
            default: k = base + $urandom_range(0, 200) - 100;
         endcase
         base = base + $urandom_range(0, 3);
         if (r < 6) begin
            push_word(1'($urandom_range(0, 1)), 6'($urandom_range(0, 63)), $urandom);
         end else if ((gen_count < fill_target && r < 80) || gen_count == 0) begin
            push_word(MODE_INSERT, pick_handle(1'b0), k);
         end else begin
            push_word(MODE_REMOVE, pick_handle(1'b1), $urandom);
         end
      end
      stim_done = 1'b1;
   end

   // ---------------------------------------------------------------------
   // Driver: idles in bursts, predicts each word as it is accepted
   // ---------------------------------------------------------------------
   int req_gap = 0;
   int rsp_gap = 0;

   initial begin
      req_ch.valid = 1'b0;
      req_ch.data  = '0;
      rsp_ch.ready = 1'b0;
      hp_count = 0;
      for (int i = 0; i < NumHandles; i++) hnd_live[i] = 1'b0;
   end

   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            expected_rsps.push_back(heap_apply(req_type'(req_ch.data)));
            void'(pending_words.pop_front());
         end
         calm = pending_words.size() < 120;
         if (req_gap > 0) begin
            req_gap--;
            req_ch.valid <= 1'b0;
         end else if (!(req_ch.valid && !req_ch.ready) && !calm
                      && $urandom_range(0, 9) == 0) begin
            req_gap = $urandom_range(1, 11) - 1;
            req_ch.valid <= 1'b0;
         end else if (pending_words.size() > 0) begin
            req_ch.valid <= 1'b1;
            req_ch.data  <= pending_words[0];
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Monitor: compares each response word with the oldest prediction
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      rsp_type exp_w;
      if (!reset) begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_rsps.size() == 0) begin
               $display("%0t: unexpected response %p", $time, rsp_word);
               errors++;
            end else begin
               exp_w = expected_rsps.pop_front();
               if (rsp_word.head_handle !== exp_w.head_handle) begin
                  $display("%0t: head_handle exp %0d got %0d", $time,
                           exp_w.head_handle, rsp_word.head_handle);
                  errors++;
               end
               if (rsp_word.head_key !== exp_w.head_key) begin
                  $display("%0t: head_key exp %h got %h", $time,
                           exp_w.head_key, rsp_word.head_key);
                  errors++;
               end
               if (rsp_word.count !== exp_w.count) begin
                  $display("%0t: count exp %0d got %0d", $time,
                           exp_w.count, rsp_word.count);
                  errors++;
               end
               if (rsp_word.status !== exp_w.status) begin
                  $display("%0t: status exp %0d got %0d", $time,
                           exp_w.status, rsp_word.status);
                  errors++;
               end
            end
         end
         if (rsp_gap > 0) begin
            rsp_gap--;
            rsp_ch.ready <= 1'b0;
         end else if (!calm && $urandom_range(0, 7) == 0) begin
            rsp_gap = $urandom_range(1, 11) - 1;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Reset, end of run and watchdog
   // ---------------------------------------------------------------------
   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      wait (stim_done && pending_words.size() == 0 && expected_rsps.size() == 0);
      repeat (200) @(posedge clock);
      if (errors == 0 && expected_rsps.size() == 0)
         $display("** wraparound_timer_min_heap: PASSED **");
      else
         $display("** wraparound_timer_min_heap: FAILED **");
      $finish;
   end

   // room for ~550 words plus stalls, several times over
   initial begin
      #5ms;
      $display("** wraparound_timer_min_heap: FAILED **");
      $finish;
   end

endmodule

// File: sim.f
design/wtmh_pkg.sv
design/wtmh_if.sv
design/wtmh_ram.sv
design/wtmh_front.sv
design/wtmh_back.sv
design/wraparound_timer_min_heap.sv
bench/tb_wraparound_timer_min_heap.sv
